### hdl/wfssf_pkg.sv
// Package for the 802.11 source address and SSID filter.
// Holds frame offsets, the OUI table and the SSID pattern cell tables.
// No dependencies.
`timescale 1ns / 1ps

package wfssf_pkg;

   localparam int OUI_ENTRIES    = 20;
   localparam int PATTERN_COUNT  = 6;
   localparam int SSID_MAX       = 32;

   localparam int OUI_TABLE_SIZE = 20;
   localparam int OUI_USED       = (OUI_ENTRIES < OUI_TABLE_SIZE) ? OUI_ENTRIES : OUI_TABLE_SIZE;
   localparam int ENTRY_W        = 5;

   localparam int PAT_NUM        = 6;
   localparam int PAT_USED       = (PATTERN_COUNT < PAT_NUM) ? PATTERN_COUNT : PAT_NUM;
   localparam int PAT_CELLS      = 45;
   localparam int PAT_IDX_W      = 3;

   localparam logic [7:0] FC_BEACON     = 8'h80;
   localparam logic [7:0] FC_PROBE_RESP = 8'h50;
   localparam logic [7:0] ELEM_SSID     = 8'h00;

   localparam logic [6:0] POS_FC_LOW    = 7'd0;
   localparam logic [6:0] POS_FC_HIGH   = 7'd1;
   localparam logic [4:0] ADDR_OFF_STD  = 5'd10;
   localparam logic [4:0] ADDR_OFF_FDS  = 5'd16;
   localparam logic [4:0] ADDR_LEN      = 5'd6;
   localparam logic [6:0] POS_ELEM_ID   = 7'd36;
   localparam logic [6:0] POS_ELEM_LEN  = 7'd37;
   localparam logic [6:0] SSID_START    = 7'd38;
   localparam logic [6:0] POS_MAX       = 7'd127;

   localparam logic [23:0] OUI_TAB [0:OUI_TABLE_SIZE-1] = '{
      24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'h145AFC,
      24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'h940853, 24'hE4AAEA,
      24'h588E81, 24'hCCCCCC, 24'hEC1BBD, 24'h9035EA, 24'h040D84,
      24'hF082C0, 24'h1C34F1, 24'h385B44, 24'h943469, 24'hB4E3F9
   };
   localparam logic OUI_CLS [0:OUI_TABLE_SIZE-1] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
   };

   // one cell per pattern character, patterns laid end to end
   localparam logic [7:0] CELL_CHAR [0:PAT_CELLS-1] = '{
      8'h66, 8'h6C, 8'h6F, 8'h63, 8'h6B,
      8'h46, 8'h6C, 8'h6F, 8'h63, 8'h6B,
      8'h46, 8'h4C, 8'h4F, 8'h43, 8'h4B,
      8'h46, 8'h53, 8'h20, 8'h45, 8'h78, 8'h74, 8'h20,
      8'h42, 8'h61, 8'h74, 8'h74, 8'h65, 8'h72, 8'h79,
      8'h50, 8'h65, 8'h6E, 8'h67, 8'h75, 8'h69, 8'h6E,
      8'h50, 8'h69, 8'h67, 8'h76, 8'h69, 8'h73, 8'h69, 8'h6F, 8'h6E
   };
   localparam logic [PAT_IDX_W-1:0] CELL_PAT [0:PAT_CELLS-1] = '{
      3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
      3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
      3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
      3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
   };
   localparam logic CELL_FIRST [0:PAT_CELLS-1] = '{
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };
   localparam logic CELL_LAST [0:PAT_CELLS-1] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1
   };

   typedef struct packed {
      logic clear;
      logic feed;
   } cell_ctrl_type;

   typedef struct packed {
      logic               hit;
      logic [ENTRY_W-1:0] entry;
      logic               cls;
   } oui_result_type;

endpackage

### hdl/wfssf_match_cell.sv
// One character cell of the SSID substring matcher chain.
// Holds one shift-and progress bit; depends on wfssf_pkg.
`timescale 1ns / 1ps

module wfssf_match_cell
   import wfssf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          chain_in,
   input  logic [7:0]    data_byte,
   input  logic [7:0]    cell_char,
   output logic          prog,
   output logic          hit
);

   logic prog_ff;
   logic prog_in;
   logic step;

   assign step = chain_in & (data_byte == cell_char);
   assign hit  = ctrl.feed & step;
   assign prog = prog_ff;

   always_comb begin
      if (ctrl.clear) begin
         prog_in = 1'b0;
      end else if (ctrl.feed) begin
         prog_in = step;
      end else begin
         prog_in = prog_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff <= 1'b0;
      end else begin
         prog_ff <= prog_in;
      end
   end

endmodule

### hdl/wfssf_oui_lookup.sv
// OUI prefix lookup: first matching table entry and its class.
// Depends on wfssf_pkg.
`timescale 1ns / 1ps

module wfssf_oui_lookup
   import wfssf_pkg::*;
(
   input  logic           enable,
   input  logic [23:0]    prefix,
   output oui_result_type result
);

   always_comb begin
      result = '0;
      for (int i = OUI_USED - 1; i >= 0; i--) begin
         if (enable && prefix == OUI_TAB[i]) begin
            result.hit   = 1'b1;
            result.entry = ENTRY_W'(i);
            result.cls   = OUI_CLS[i];
         end
      end
   end

endmodule

### hdl/wifi_frame_source_ssid_filter_top.sv
// Top level of the 802.11 source address and SSID filter.
// Depends on wfssf_pkg, wfssf_match_cell and wfssf_oui_lookup.
`timescale 1ns / 1ps

// Takes one frame byte per cycle on the req_ channel and gives one summary
// word on the rsp_ channel, registered, the cycle after the byte marked
// last_byte is taken. A new byte is taken each cycle unless a finished word
// waits with rsp_stall high. The SSID is
// searched by a chain of one cell per pattern character, all stepping on
// the same byte, so the rate does not depend on SSID length.
module wifi_frame_source_ssid_filter_top
   import wfssf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               req_frame_is_mgmt,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_has_source,
   output logic [47:0]        rsp_source_address,
   output logic               rsp_oui_hit,
   output logic [ENTRY_W-1:0] rsp_oui_entry,
   output logic               rsp_oui_class,
   output logic               rsp_ssid_seen,
   output logic [PAT_NUM-1:0] rsp_ssid_hits,
   output logic               rsp_detection
);

   logic               req_accept;
   logic               frame_end;

   logic [6:0]         pos_ff, pos_in;
   logic               mgmt_ff, mgmt_in;
   logic [7:0]         fc_low_ff, fc_low_in;
   logic [7:0]         fc_high_ff, fc_high_in;
   logic [47:0]        addr_ff, addr_in;
   logic [7:0]         elem_id_ff, elem_id_in;
   logic [7:0]         elem_len_ff, elem_len_in;
   logic               ended_ff, ended_in;
   logic [PAT_NUM-1:0] found_ff, found_in;

   logic [4:0]         addr_off;
   logic [5:0]         ssid_n;
   logic               in_ssid;
   logic               feed;
   cell_ctrl_type      cell_ctrl;
   logic [PAT_CELLS-1:0] cell_prog;
   logic [PAT_CELLS-1:0] cell_hit;
   logic [PAT_NUM-1:0] found_now;

   logic [7:0]         count;
   logic [4:0]         res_off;
   logic [5:0]         res_ssid_n;
   logic               res_has_src;
   logic               res_seen;
   logic [PAT_NUM-1:0] res_hits;
   oui_result_type     oui_res;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               has_src_ff;
   logic [47:0]        src_ff;
   oui_result_type     oui_ff;
   logic               seen_ff;
   logic [PAT_NUM-1:0] hits_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign frame_end  = req_accept & req_last_byte;

   // frame parsing
   always_comb begin
      addr_off = (fc_high_ff[1] && !fc_high_ff[0]) ? ADDR_OFF_FDS : ADDR_OFF_STD;
      ssid_n   = (elem_len_ff < 8'(SSID_MAX)) ? elem_len_ff[5:0] : 6'(SSID_MAX);
      in_ssid  = (pos_ff >= SSID_START) && ((pos_ff - SSID_START) < {1'b0, ssid_n})
                 && !ended_ff;

      mgmt_in     = mgmt_ff;
      fc_low_in   = fc_low_ff;
      fc_high_in  = fc_high_ff;
      addr_in     = addr_ff;
      elem_id_in  = elem_id_ff;
      elem_len_in = elem_len_ff;
      ended_in    = ended_ff;
      pos_in      = pos_ff;
      feed        = 1'b0;

      if (req_accept) begin
         if (pos_ff == POS_FC_LOW) begin
            fc_low_in = req_data_byte;
            mgmt_in   = req_frame_is_mgmt;
         end else if (pos_ff == POS_FC_HIGH) begin
            fc_high_in = req_data_byte;
         end
         if (pos_ff >= {2'b00, addr_off} && pos_ff < {2'b00, addr_off + ADDR_LEN}) begin
            addr_in = {addr_ff[39:0], req_data_byte};
         end
         if (pos_ff == POS_ELEM_ID) begin
            elem_id_in = req_data_byte;
         end else if (pos_ff == POS_ELEM_LEN) begin
            elem_len_in = req_data_byte;
         end else if (in_ssid) begin
            if (req_data_byte == 8'h00) begin
               ended_in = 1'b1;
            end else begin
               feed = 1'b1;
            end
         end
         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   assign cell_ctrl.clear = frame_end;
   assign cell_ctrl.feed  = feed;

   generate
      for (genvar c = 0; c < PAT_CELLS; c++) begin : g_cell
         logic chain;
         if (c == 0) begin : g_head
            assign chain = 1'b1;
         end else begin : g_link
            assign chain = CELL_FIRST[c] ? 1'b1 : cell_prog[c-1];
         end
         wfssf_match_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .chain_in  (chain),
            .data_byte (req_data_byte),
            .cell_char (CELL_CHAR[c]),
            .prog      (cell_prog[c]),
            .hit       (cell_hit[c])
         );
      end
   endgenerate

   always_comb begin
      found_now = '0;
      for (int c = 0; c < PAT_CELLS; c++) begin
         if (CELL_LAST[c] && int'(CELL_PAT[c]) < PAT_USED) begin
            found_now[CELL_PAT[c]] = found_now[CELL_PAT[c]] | cell_hit[c];
         end
      end
   end

   assign found_in = found_ff | found_now;

   // summary word, from the values updated with the last byte
   always_comb begin
      count       = {1'b0, pos_ff} + 8'd1;
      res_off     = (fc_high_in[1] && !fc_high_in[0]) ? ADDR_OFF_FDS : ADDR_OFF_STD;
      res_ssid_n  = (elem_len_in < 8'(SSID_MAX)) ? elem_len_in[5:0] : 6'(SSID_MAX);
      res_has_src = !(fc_high_in[1] && fc_high_in[0]) &&
                    (count >= {3'b000, res_off + ADDR_LEN});
      res_seen    = mgmt_in && (fc_low_in == FC_BEACON || fc_low_in == FC_PROBE_RESP) &&
                    (elem_id_in == ELEM_SSID) && (elem_len_in != 8'h00) &&
                    (count >= ({1'b0, SSID_START} + {2'b00, res_ssid_n}));
      res_hits    = res_seen ? found_in : '0;
   end

   wfssf_oui_lookup u_oui (
      .enable (res_has_src),
      .prefix (addr_in[47:24]),
      .result (oui_res)
   );

   always_ff @(posedge clock) begin
      if (reset || frame_end) begin
         pos_ff      <= '0;
         mgmt_ff     <= 1'b0;
         fc_low_ff   <= '0;
         fc_high_ff  <= '0;
         addr_ff     <= '0;
         elem_id_ff  <= '0;
         elem_len_ff <= '0;
         ended_ff    <= 1'b0;
         found_ff    <= '0;
      end else begin
         pos_ff      <= pos_in;
         mgmt_ff     <= mgmt_in;
         fc_low_ff   <= fc_low_in;
         fc_high_ff  <= fc_high_in;
         addr_ff     <= addr_in;
         elem_id_ff  <= elem_id_in;
         elem_len_ff <= elem_len_in;
         ended_ff    <= ended_in;
         found_ff    <= found_in;
      end
   end

   // output word register
   always_comb begin
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_end) begin
         has_src_ff <= res_has_src;
         src_ff     <= res_has_src ? addr_in : '0;
         oui_ff     <= oui_res;
         seen_ff    <= res_seen;
         hits_ff    <= res_hits;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_has_source     = has_src_ff;
   assign rsp_source_address = src_ff;
   assign rsp_oui_hit        = oui_ff.hit;
   assign rsp_oui_entry      = oui_ff.entry;
   assign rsp_oui_class      = oui_ff.cls;
   assign rsp_ssid_seen      = seen_ff;
   assign rsp_ssid_hits      = hits_ff;
   assign rsp_detection      = oui_ff.hit | (|hits_ff);

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (pos_ff == '0 && found_ff == '0 && cell_prog == '0))
      else $error("frame state not cleared after last word");

   a_no_source_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_source) |-> (rsp_source_address == '0 && !rsp_oui_hit))
      else $error("source fields set without a source address");

   a_hits_need_ssid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ssid_seen) |-> (rsp_ssid_hits == '0))
      else $error("ssid hits without an ssid");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_source_address)))
      else $error("stalled result word changed");

endmodule

### dv/testbench.sv
// Testbench for wifi_frame_source_ssid_filter_top: sends 802.11 frames byte by byte and
// checks each summary word against a frame tracker kept here. Depends on wfssf_pkg
// for port widths and on the filter RTL.
`timescale 1ns / 1ps

module testbench
   import wfssf_pkg::*;
;

   localparam logic [7:0] BEACON         = 8'h80;
   localparam logic [7:0] PROBE_RSP      = 8'h50;
   localparam logic [7:0] DATA_TYPE      = 8'h08;
   localparam logic [7:0] TO_DS          = 8'h01;
   localparam logic [7:0] FROM_DS        = 8'h02;
   localparam int         SSID_AT        = 38;
   localparam int         SSID_CAP       = 32;
   localparam int         OUI_COUNT      = 20;
   localparam int         FIRST_BATTERY  = 10;
   localparam int         RANDOM_BYTES   = 120;
   localparam int         MIN_FRAMES     = 3;
   localparam int         TAIL_CYCLES    = 8;
   localparam int         WATCHDOG_LIMIT = 2000;

   localparam logic [23:0] OUI_LIST [0:OUI_COUNT-1] = '{
      24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'h145AFC,
      24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'h940853, 24'hE4AAEA,
      24'h588E81, 24'hCCCCCC, 24'hEC1BBD, 24'h9035EA, 24'h040D84,
      24'hF082C0, 24'h1C34F1, 24'h385B44, 24'h943469, 24'hB4E3F9
   };

   // substring patterns, stored end to end
   localparam int PAT_LEN [0:5] = '{5, 5, 5, 14, 7, 9};
   localparam int PAT_OFF [0:5] = '{0, 5, 10, 15, 29, 36};
   localparam logic [7:0] PAT_TXT [0:44] = '{
      8'h66, 8'h6C, 8'h6F, 8'h63, 8'h6B,
      8'h46, 8'h6C, 8'h6F, 8'h63, 8'h6B,
      8'h46, 8'h4C, 8'h4F, 8'h43, 8'h4B,
      8'h46, 8'h53, 8'h20, 8'h45, 8'h78, 8'h74, 8'h20,
      8'h42, 8'h61, 8'h74, 8'h74, 8'h65, 8'h72, 8'h79,
      8'h50, 8'h65, 8'h6E, 8'h67, 8'h75, 8'h69, 8'h6E,
      8'h50, 8'h69, 8'h67, 8'h76, 8'h69, 8'h73, 8'h69, 8'h6F, 8'h6E
   };

   typedef struct packed {
      logic               has_src;
      logic [47:0]        src;
      logic               oui_hit;
      logic [ENTRY_W-1:0] entry;
      logic               cls;
      logic               seen;
      logic [PAT_NUM-1:0] hits;
      logic               det;
   } summary_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [7:0]         req_data_byte;
   logic               req_frame_is_mgmt;
   logic               req_last_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_has_source;
   logic [47:0]        rsp_source_address;
   logic               rsp_oui_hit;
   logic [ENTRY_W-1:0] rsp_oui_entry;
   logic               rsp_oui_class;
   logic               rsp_ssid_seen;
   logic [PAT_NUM-1:0] rsp_ssid_hits;
   logic               rsp_detection;

   summary_type pending_summaries[$];
   logic [7:0]  frame_buf[$];
   int          errors      = 0;
   int          idle_cycles = 0;
   int          burst_left  = 0;
   int          gap_max     = 0;

   // frame tracker state
   int unsigned frame_pos;
   logic        frame_mgmt;
   logic [7:0]  type_byte;
   logic [7:0]  flags_byte;
   logic [47:0] addr_shift;
   logic [7:0]  elem_id;
   logic [7:0]  elem_len;
   logic        ssid_cut;
   logic [7:0]  ssid_text[$];

   wifi_frame_source_ssid_filter_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_is_mgmt  (req_frame_is_mgmt),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_has_source     (rsp_has_source),
      .rsp_source_address (rsp_source_address),
      .rsp_oui_hit        (rsp_oui_hit),
      .rsp_oui_entry      (rsp_oui_entry),
      .rsp_oui_class      (rsp_oui_class),
      .rsp_ssid_seen      (rsp_ssid_seen),
      .rsp_ssid_hits      (rsp_ssid_hits),
      .rsp_detection      (rsp_detection)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic clear_frame_state();
      frame_pos  = 0;
      frame_mgmt = 1'b0;
      type_byte  = 8'h00;
      flags_byte = 8'h00;
      addr_shift = 48'h0;
      elem_id    = 8'h00;
      elem_len   = 8'h00;
      ssid_cut   = 1'b0;
      ssid_text.delete();
   endtask

   function automatic logic ssid_has(input int p);
      logic hit, ok;
      int   st, k;
      hit = 1'b0;
      for (st = 0; st + PAT_LEN[p] <= ssid_text.size(); st++) begin
         ok = 1'b1;
         for (k = 0; k < PAT_LEN[p]; k++)
            if (ssid_text[st + k] != PAT_TXT[PAT_OFF[p] + k]) ok = 1'b0;
         if (ok) hit = 1'b1;
      end
      return hit;
   endfunction

   // updates the tracker with one accepted word; queues a summary on the last byte
   task automatic absorb_frame_byte(input logic [7:0] b, input logic mg, input logic lst);
      int unsigned idx, aoff, slen, cnt;
      int          e, p;
      summary_type s;
      idx  = frame_pos;
      aoff = (flags_byte[1] && !flags_byte[0]) ? 16 : 10;
      slen = (elem_len < SSID_CAP) ? elem_len : SSID_CAP;
      if (idx == 0) begin
         type_byte  = b;
         frame_mgmt = mg;
      end else if (idx == 1) begin
         flags_byte = b;
      end
      if (idx >= aoff && idx < aoff + 6) addr_shift = {addr_shift[39:0], b};
      if (idx == 36) begin
         elem_id = b;
      end else if (idx == 37) begin
         elem_len = b;
      end else if (idx >= SSID_AT && idx - SSID_AT < slen && !ssid_cut) begin
         if (b == 8'h00) ssid_cut = 1'b1;
         else ssid_text.push_back(b);
      end
      if (frame_pos < 127) frame_pos++;
      if (lst) begin
         cnt  = idx + 1;
         aoff = (flags_byte[1] && !flags_byte[0]) ? 16 : 10;
         slen = (elem_len < SSID_CAP) ? elem_len : SSID_CAP;
         s = '0;
         s.has_src = !(flags_byte[0] && flags_byte[1]) && cnt >= aoff + 6;
         if (s.has_src) begin
            s.src = addr_shift;
            for (e = 0; e < OUI_COUNT; e++)
               if (!s.oui_hit && addr_shift[47:24] == OUI_LIST[e]) begin
                  s.oui_hit = 1'b1;
                  s.entry   = ENTRY_W'(e);
                  s.cls     = (e >= FIRST_BATTERY);
               end
         end
         s.seen = frame_mgmt && (type_byte == BEACON || type_byte == PROBE_RSP) &&
                  elem_id == ELEM_SSID && elem_len != 0 && cnt >= SSID_AT + slen;
         if (s.seen)
            for (p = 0; p < PAT_NUM; p++) s.hits[p] = ssid_has(p);
         s.det = s.oui_hit || (s.hits != 0);
         pending_summaries.push_back(s);
         clear_frame_state();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic mg, input logic lst);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (gap_max != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_frame_is_mgmt <= mg;
      req_last_byte     <= lst;
      do @(posedge clock); while (req_stall);
      absorb_frame_byte(b, mg, lst);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_summaries.size() != 0) @(posedge clock);
   endtask

   task automatic set_byte(input int i, input logic [7:0] v);
      if (i < frame_buf.size()) frame_buf[i] = v;
   endtask

   task automatic put_pattern(input int at, input int p);
      int k;
      for (k = 0; k < PAT_LEN[p]; k++) set_byte(at + k, PAT_TXT[PAT_OFF[p] + k]);
   endtask

   task automatic build_frame(input logic [7:0] fc0, input logic [7:0] fc1,
                              input logic [23:0] oui, input logic [7:0] eid,
                              input logic [7:0] elen, input int total);
      int i, aoff, slen;
      frame_buf.delete();
      for (i = 0; i < total; i++) frame_buf.push_back(8'($urandom));
      aoff = (fc1[1] && !fc1[0]) ? 16 : 10;
      slen = (elen < SSID_CAP) ? elen : SSID_CAP;
      set_byte(0, fc0);
      set_byte(1, fc1);
      set_byte(aoff, oui[23:16]);
      set_byte(aoff + 1, oui[15:8]);
      set_byte(aoff + 2, oui[7:0]);
      set_byte(36, eid);
      set_byte(37, elen);
      for (i = 0; i < slen; i++) set_byte(SSID_AT + i, 8'($urandom_range(1, 255)));
   endtask

   task automatic send_frame(input logic mg);
      int i;
      for (i = 0; i < frame_buf.size(); i++)
         send_byte(frame_buf[i], (i == 0) ? mg : 1'($urandom_range(0, 1)),
                   i == frame_buf.size() - 1);
   endtask

   task automatic test_address_position();
      gap_max = 0;
      build_frame(BEACON, 8'h00, OUI_LIST[0], ELEM_SSID, 8'd4, 1);
      send_frame(1'b1);
      build_frame(BEACON, 8'h00, OUI_LIST[1], ELEM_SSID, 8'd4, 2);
      send_frame(1'b1);
      build_frame(DATA_TYPE, 8'h00, OUI_LIST[2], ELEM_SSID, 8'd4, 15);
      send_frame(1'b0);
      build_frame(DATA_TYPE, 8'h00, OUI_LIST[2], ELEM_SSID, 8'd4, 16);
      send_frame(1'b0);
      build_frame(DATA_TYPE, FROM_DS, OUI_LIST[3], ELEM_SSID, 8'd4, 21);
      send_frame(1'b0);
      build_frame(DATA_TYPE, FROM_DS, OUI_LIST[3], ELEM_SSID, 8'd4, 22);
      send_frame(1'b0);
      build_frame(DATA_TYPE, TO_DS | FROM_DS, OUI_LIST[4], ELEM_SSID, 8'd4, 30);
      send_frame(1'b0);
      build_frame(DATA_TYPE, TO_DS, OUI_LIST[5], ELEM_SSID, 8'd4, 16);
      send_frame(1'b0);
      wait_drained();
   endtask

   task automatic test_oui_table();
      int          picks [4] = '{0, 9, 10, 19};
      int          i, j;
      logic [7:0]  fill;
      gap_max = 3;
      for (i = 0; i < 4; i++) begin
         build_frame(DATA_TYPE, 8'h00, OUI_LIST[picks[i]], ELEM_SSID, 8'd0, 24);
         send_frame(1'b0);
      end
      build_frame(DATA_TYPE, 8'h00, 24'h000001, ELEM_SSID, 8'd0, 24);
      send_frame(1'b0);
      // all-zero and all-ones frames
      for (j = 0; j < 3; j++) begin
         fill = (j == 0) ? 8'h00 : 8'hFF;
         build_frame(fill, fill, {3{fill}}, fill, fill, 24);
         for (i = 0; i < 24; i++) frame_buf[i] = fill;
         if (j == 2) set_byte(1, 8'h00);
         send_frame(fill[0]);
      end
      wait_drained();
   endtask

   task automatic test_ssid_patterns();
      int p, i;
      gap_max = 5;
      for (p = 0; p < PAT_NUM; p++) begin
         build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'(PAT_LEN[p]),
                     SSID_AT + PAT_LEN[p]);
         put_pattern(SSID_AT, p);
         send_frame(1'b1);
      end
      build_frame(PROBE_RSP, 8'h00, 24'h000001, ELEM_SSID, 8'd32, 70);
      put_pattern(SSID_AT + 18, 3);
      send_frame(1'b1);
      // pattern straddles the 32-byte cut
      build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'd40, 80);
      put_pattern(SSID_AT + 30, 0);
      send_frame(1'b1);
      // NUL ends the SSID before the pattern
      build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'd20, 58);
      set_byte(40, 8'h00);
      put_pattern(45, 4);
      send_frame(1'b1);
      build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'd9, 47);
      put_pattern(SSID_AT, 5);
      send_frame(1'b0);
      build_frame(BEACON, 8'h00, 24'h000001, 8'h01, 8'd9, 47);
      put_pattern(SSID_AT, 5);
      send_frame(1'b1);
      build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'd0, 50);
      put_pattern(SSID_AT, 1);
      send_frame(1'b1);
      // frame ends one byte short of the SSID
      build_frame(PROBE_RSP, 8'h00, 24'h000001, ELEM_SSID, 8'd20, 57);
      put_pattern(SSID_AT, 1);
      send_frame(1'b1);
      build_frame(DATA_TYPE, 8'h00, 24'h000001, ELEM_SSID, 8'd9, 47);
      put_pattern(SSID_AT, 5);
      send_frame(1'b1);
      build_frame(BEACON, 8'h00, OUI_LIST[12], ELEM_SSID, 8'd255, 70);
      put_pattern(SSID_AT + 23, 5);
      send_frame(1'b1);
      build_frame(BEACON, 8'h00, 24'h000001, ELEM_SSID, 8'd32, 70);
      for (i = 0; i < 32; i++) set_byte(SSID_AT + i, 8'hFF);
      send_frame(1'b1);
      wait_drained();
   endtask

   task automatic test_long_frames();
      int lens [2] = '{127, 128};
      int i;
      gap_max = 2;
      for (i = 0; i < 2; i++) begin
         build_frame(BEACON, 8'h00, OUI_LIST[19], ELEM_SSID, 8'd14, lens[i]);
         put_pattern(SSID_AT, 3);
         send_frame(1'b1);
      end
      wait_drained();
   endtask

   task automatic random_frame();
      logic [7:0]  fc0, fc1, eid, elen;
      logic [23:0] oui;
      int          pick, slen, total, k, p;
      pick = $urandom_range(0, 9);
      fc0  = (pick < 4) ? BEACON : (pick < 7) ? PROBE_RSP : 8'($urandom);
      fc1  = 8'($urandom);
      oui  = ($urandom_range(0, 2) != 0) ? OUI_LIST[$urandom_range(0, OUI_COUNT - 1)]
                                         : 24'($urandom);
      eid  = ($urandom_range(0, 7) != 0) ? ELEM_SSID : 8'($urandom);
      pick = $urandom_range(0, 19);
      elen = (pick == 0) ? 8'd0 : (pick == 1) ? 8'($urandom_range(33, 255))
                                              : 8'($urandom_range(1, 32));
      slen = (elen < SSID_CAP) ? elen : SSID_CAP;
      pick = $urandom_range(0, 19);
      if (pick < 9) total = SSID_AT + slen + $urandom_range(0, 8);
      else if (pick < 13) total = $urandom_range(1, 24);
      else if (pick < 18) total = $urandom_range(25, SSID_AT + slen);
      else total = $urandom_range(100, 180);
      build_frame(fc0, fc1, oui, eid, elen, total);
      for (k = 0; k < slen; k++) begin
         pick = $urandom_range(0, 149);
         if (pick == 0) set_byte(SSID_AT + k, 8'h00);
         else if (pick < 75) set_byte(SSID_AT + k, PAT_TXT[$urandom_range(0, 44)]);
      end
      p = $urandom_range(0, PAT_NUM - 1);
      if ($urandom_range(0, 1) == 1 && PAT_LEN[p] <= slen)
         put_pattern(SSID_AT + $urandom_range(0, slen - PAT_LEN[p]), p);
      send_frame(1'($urandom_range(0, 7) != 0));
   endtask

   task automatic test_random_traffic();
      int frames, bytes;
      frames = 0;
      bytes  = 0;
      while (bytes < RANDOM_BYTES || frames < MIN_FRAMES) begin
         if ($urandom_range(0, 3) == 0)
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         random_frame();
         bytes += frame_buf.size();
         frames++;
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
   endtask

   task automatic check_field(input string what, input logic [47:0] want,
                              input logic [47:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      summary_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: summary word with none expected, expected none, actual %h",
                     $time, rsp_source_address);
            errors++;
         end else begin
            want = pending_summaries.pop_front();
            check_field("has_source", want.has_src, rsp_has_source);
            check_field("source_address", want.src, rsp_source_address);
            check_field("oui_hit", want.oui_hit, rsp_oui_hit);
            check_field("oui_entry", want.entry, rsp_oui_entry);
            check_field("oui_class", want.cls, rsp_oui_class);
            check_field("ssid_seen", want.seen, rsp_ssid_seen);
            check_field("ssid_hits", want.hits, rsp_ssid_hits);
            check_field("detection", want.det, rsp_detection);
         end
      end
   end

   // receiver stall pattern: open, sparse random, long runs, or periodic
   initial begin : rsp_pacer
      int   mode, run, hold, tick;
      logic level;
      rsp_stall <= 1'b0;
      mode  = 0;
      run   = 100;
      hold  = 0;
      tick  = 0;
      level = 1'b0;
      forever begin
         @(posedge clock);
         if (run == 0) begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(50, 300);
         end
         run--;
         tick++;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: begin
               if (hold == 0) begin
                  level = ~level;
                  hold  = $urandom_range(1, 16);
               end
               hold--;
               rsp_stall <= level;
            end
            default: rsp_stall <= (tick % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[wifi_frame_source_ssid_filter_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_frame_is_mgmt <= 1'b0;
      req_last_byte     <= 1'b0;
      clear_frame_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_address_position();
      test_oui_table();
      test_ssid_patterns();
      test_long_frames();
      test_random_traffic();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[wifi_frame_source_ssid_filter_top] OK");
      end else begin
         $display("[wifi_frame_source_ssid_filter_top] ERROR");
      end
      $finish;
   end

endmodule
